/* src/tcmp_pkg.sv */
// ----------------------------------------------------------------------------
// tcmp_pkg
// shared constants, field layout and control types for the track cut
// multiplicity profile
// ----------------------------------------------------------------------------
package tcmp_pkg;

    // histogram geometry
    localparam int NUM_BINS = 256;
    localparam int BIN_W    = $clog2(NUM_BINS);
    localparam logic [31:0] LAST_BIN = 32'(NUM_BINS - 1);

    // field widths
    localparam int CMD_W  = 2;
    localparam int PT_W   = 20;
    localparam int ETA_W  = 16;
    localparam int PID_W  = 32;
    localparam int SEL_W  = 8;
    localparam int IDX_W  = 8;
    localparam int TOT_W  = 32;
    localparam int CHG_W  = 40;
    localparam int MEAN_W = 17;
    localparam int MULT_W = 8;
    localparam int ECHG_W = 9;
    localparam int LIM_W  = 15;

    // input tdata layout, lowest field first
    localparam int PT_LSB    = 0;
    localparam int ETA_LSB   = PT_LSB + PT_W;
    localparam int PID_LSB   = ETA_LSB + ETA_W;
    localparam int SEL_LSB   = PID_LSB + PID_W;
    localparam int S_USED_W  = SEL_LSB + SEL_W;
    localparam int S_TDATA_W = ((S_USED_W + 7) / 8) * 8;

    // output tdata layout, lowest field first
    localparam int IDX_LSB   = 0;
    localparam int TOT_LSB   = IDX_LSB + IDX_W;
    localparam int CHG_LSB   = TOT_LSB + TOT_W;
    localparam int MEAN_LSB  = CHG_LSB + CHG_W;
    localparam int M_USED_W  = MEAN_LSB + MEAN_W;
    localparam int M_TDATA_W = ((M_USED_W + 7) / 8) * 8;

    // divider: |sum| scaled by 2^8 over the event count
    localparam int FRAC_W  = 8;
    localparam int DIV_W   = CHG_W + FRAC_W;
    localparam int STEP_W  = $clog2(DIV_W);

    // configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 20;
    localparam logic [CFG_IDX_W-1:0] CFG_PT_THR  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ETA_LIM = 1'd1;
    localparam logic [PT_W-1:0]  PT_THR_RST  = 20'd50;
    localparam logic [LIM_W-1:0] ETA_LIM_RST = 15'd4096;

    // command codes carried in tuser
    localparam logic [CMD_W-1:0] CMD_TRACK = 2'd0;
    localparam logic [CMD_W-1:0] CMD_EOE   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

    // controller to datapath commands
    typedef struct packed {
        logic clr_wr;    // clearing pass writes one zero entry
        logic trk_en;    // track transaction accepted
        logic addr_lat;  // latch bin address of an accepted transaction
        logic upd_wr;    // end of event read-modify-write
        logic div_load;  // load divider from read data
        logic div_step;  // one divider iteration
        logic out_load;  // move result into output register
    } t_dp_cmd;

    // datapath to controller status
    typedef struct packed {
        logic clr_last;
        logic div_last;
        logic out_busy;
    } t_dp_stat;

endpackage

/* src/tcmp_ctrl.sv */
// ----------------------------------------------------------------------------
// tcmp_ctrl
// sequencer for clearing pass, event update, bin read and division
// ----------------------------------------------------------------------------
module tcmp_ctrl (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_s_valid,
    input  logic [tcmp_pkg::CMD_W-1:0]   i_s_cmd,
    input  tcmp_pkg::t_dp_stat           i_stat,
    output logic                         o_s_ready,
    output tcmp_pkg::t_dp_cmd            o_cmd
);

    typedef enum logic [5:0] {
        S_CLEAR  = 6'b000001,
        S_IDLE   = 6'b000010,
        S_UPDATE = 6'b000100,
        S_LOAD   = 6'b001000,
        S_DIV    = 6'b010000,
        S_DONE   = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state   = r_state;
        o_cmd     = '0;
        o_s_ready = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_s_ready = 1'b1;
                if (i_s_valid) begin
                    o_cmd.addr_lat = 1'b1;
                    unique case (i_s_cmd)
                        tcmp_pkg::CMD_TRACK: o_cmd.trk_en = 1'b1;
                        tcmp_pkg::CMD_EOE:   n_state = S_UPDATE;
                        tcmp_pkg::CMD_READ:  n_state = S_LOAD;
                        default:             n_state = S_IDLE;
                    endcase
                end
            end
            S_UPDATE: begin
                o_cmd.upd_wr = 1'b1;
                n_state      = S_IDLE;
            end
            S_LOAD: begin
                o_cmd.div_load = 1'b1;
                n_state        = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!i_stat.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_CLEAR;
        endcase
    end

endmodule

/* src/tcmp_dp.sv */
// ----------------------------------------------------------------------------
// tcmp_dp
// track cuts, event counters, histogram memory, mean divider, output register
// ----------------------------------------------------------------------------
module tcmp_dp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  tcmp_pkg::t_dp_cmd                 i_cmd,
    output tcmp_pkg::t_dp_stat                o_stat,
    input  logic [tcmp_pkg::CMD_W-1:0]        i_s_cmd,
    input  logic [tcmp_pkg::S_TDATA_W-1:0]    i_s_data,
    input  logic                              i_cfg_wr_en,
    input  logic [tcmp_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [tcmp_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    input  logic                              i_m_tready,
    output logic                              o_m_tvalid,
    output logic [tcmp_pkg::M_TDATA_W-1:0]    o_m_tdata
);

    localparam int BW = tcmp_pkg::BIN_W;
    localparam int DW = tcmp_pkg::DIV_W;

    // histogram memory
    logic [tcmp_pkg::TOT_W-1:0]        mem_cnt [tcmp_pkg::NUM_BINS];
    logic signed [tcmp_pkg::CHG_W-1:0] mem_sum [tcmp_pkg::NUM_BINS];

    // configuration registers
    logic [tcmp_pkg::PT_W-1:0]  r_pt_thr;
    logic [tcmp_pkg::LIM_W-1:0] r_eta_lim;

    // event counters
    logic [tcmp_pkg::MULT_W-1:0]        r_mult;
    logic signed [tcmp_pkg::ECHG_W-1:0] r_echg;

    // addressing
    logic [BW-1:0]              r_clr_addr;
    logic [BW-1:0]              r_addr;
    logic [tcmp_pkg::IDX_W-1:0] r_bin_idx;
    logic [BW-1:0]              w_rd_addr;
    logic [BW-1:0]              w_eoe_addr;
    logic [BW-1:0]              w_sel_addr;
    logic [31:0]                w_mult32;
    logic [31:0]                w_sel32;
    logic [31:0]                w_sel_clamp;

    // memory read data
    logic [tcmp_pkg::TOT_W-1:0]        r_rd_cnt;
    logic signed [tcmp_pkg::CHG_W-1:0] r_rd_sum;

    // memory write port
    logic                              w_mem_we;
    logic [BW-1:0]                     w_wr_addr;
    logic [tcmp_pkg::TOT_W-1:0]        w_wr_cnt;
    logic signed [tcmp_pkg::CHG_W-1:0] w_wr_sum;
    logic [tcmp_pkg::TOT_W-1:0]        w_new_cnt;
    logic signed [tcmp_pkg::CHG_W:0]   w_sum_ext;
    logic signed [tcmp_pkg::CHG_W-1:0] w_new_sum;

    // track fields and cuts
    logic [tcmp_pkg::PT_W-1:0]          w_pt;
    logic signed [tcmp_pkg::ETA_W-1:0]  w_eta;
    logic signed [tcmp_pkg::PID_W-1:0]  w_pid;
    logic [tcmp_pkg::SEL_W-1:0]         w_sel;
    logic signed [tcmp_pkg::ETA_W:0]    w_eta_x;
    logic signed [tcmp_pkg::ETA_W:0]    w_lim_x;
    logic signed [tcmp_pkg::ETA_W:0]    w_nlim_x;
    logic                               w_pass;
    logic                               w_pid_pos;
    logic                               w_pid_neg;

    // divider
    logic [tcmp_pkg::TOT_W-1:0]        r_tot;
    logic signed [tcmp_pkg::CHG_W-1:0] r_chg;
    logic                              r_neg;
    logic [DW-1:0]                     r_dq;
    logic [tcmp_pkg::TOT_W-1:0]        r_rem;
    logic [tcmp_pkg::STEP_W-1:0]       r_step;
    logic [tcmp_pkg::CHG_W-1:0]        w_mag;
    logic [tcmp_pkg::TOT_W:0]          w_rem_sh;
    logic [tcmp_pkg::TOT_W:0]          w_rem_sub;
    logic                              w_ge;
    logic signed [tcmp_pkg::MEAN_W-1:0] w_mean;

    // output register
    logic                              r_m_valid;
    logic [tcmp_pkg::M_TDATA_W-1:0]    r_m_data;

    // field extraction
    assign w_pt  = i_s_data[tcmp_pkg::PT_LSB  +: tcmp_pkg::PT_W];
    assign w_eta = i_s_data[tcmp_pkg::ETA_LSB +: tcmp_pkg::ETA_W];
    assign w_pid = i_s_data[tcmp_pkg::PID_LSB +: tcmp_pkg::PID_W];
    assign w_sel = i_s_data[tcmp_pkg::SEL_LSB +: tcmp_pkg::SEL_W];

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pt_thr  <= tcmp_pkg::PT_THR_RST;
            r_eta_lim <= tcmp_pkg::ETA_LIM_RST;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                tcmp_pkg::CFG_PT_THR:  r_pt_thr  <= i_cfg_wdata[tcmp_pkg::PT_W-1:0];
                tcmp_pkg::CFG_ETA_LIM: r_eta_lim <= i_cfg_wdata[tcmp_pkg::LIM_W-1:0];
                default: ;
            endcase
        end
    end

    // track selection: pt above threshold, eta strictly inside the window
    assign w_eta_x   = {w_eta[tcmp_pkg::ETA_W-1], w_eta};
    assign w_lim_x   = $signed({2'b00, r_eta_lim});
    assign w_nlim_x  = -w_lim_x;
    assign w_pass    = (w_pt > r_pt_thr) && (w_eta_x < w_lim_x) && (w_eta_x > w_nlim_x);
    assign w_pid_neg = w_pid[tcmp_pkg::PID_W-1];
    assign w_pid_pos = !w_pid_neg && (w_pid != '0);

    // event counters, cleared by the end of event write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mult <= '0;
            r_echg <= '0;
        end else if (i_cmd.upd_wr) begin
            r_mult <= '0;
            r_echg <= '0;
        end else if (i_cmd.trk_en && w_pass) begin
            if (r_mult != '1) begin
                r_mult <= r_mult + 1'b1;
            end
            if (w_pid_pos && (r_echg != 9'sd255)) begin
                r_echg <= r_echg + 9'sd1;
            end else if (w_pid_neg && (r_echg != -9'sd256)) begin
                r_echg <= r_echg - 9'sd1;
            end
        end
    end

    // bin addresses clamped to the top bin
    assign w_mult32    = {{(32-tcmp_pkg::MULT_W){1'b0}}, r_mult};
    assign w_eoe_addr  = (w_mult32 > tcmp_pkg::LAST_BIN) ? tcmp_pkg::LAST_BIN[BW-1:0]
                                                         : w_mult32[BW-1:0];
    assign w_sel32     = {{(32-tcmp_pkg::SEL_W){1'b0}}, w_sel};
    assign w_sel_clamp = (w_sel32 > tcmp_pkg::LAST_BIN) ? tcmp_pkg::LAST_BIN : w_sel32;
    assign w_sel_addr  = w_sel_clamp[BW-1:0];
    assign w_rd_addr   = (i_s_cmd == tcmp_pkg::CMD_EOE) ? w_eoe_addr : w_sel_addr;

    always_ff @(posedge i_clk) begin
        if (i_cmd.addr_lat) begin
            r_addr    <= w_rd_addr;
            r_bin_idx <= w_sel_clamp[tcmp_pkg::IDX_W-1:0];
        end
    end

    // clearing pass counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clr_wr) begin
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end
    assign o_stat.clr_last = (r_clr_addr == tcmp_pkg::LAST_BIN[BW-1:0]);

    // saturating bin update
    assign w_new_cnt = (r_rd_cnt == '1) ? r_rd_cnt : r_rd_cnt + 1'b1;
    assign w_sum_ext = {r_rd_sum[tcmp_pkg::CHG_W-1], r_rd_sum}
                     + {{(tcmp_pkg::CHG_W+1-tcmp_pkg::ECHG_W){r_echg[tcmp_pkg::ECHG_W-1]}},
                        r_echg};
    always_comb begin
        if (w_sum_ext[tcmp_pkg::CHG_W] != w_sum_ext[tcmp_pkg::CHG_W-1]) begin
            w_new_sum = w_sum_ext[tcmp_pkg::CHG_W]
                      ? {1'b1, {(tcmp_pkg::CHG_W-1){1'b0}}}
                      : {1'b0, {(tcmp_pkg::CHG_W-1){1'b1}}};
        end else begin
            w_new_sum = w_sum_ext[tcmp_pkg::CHG_W-1:0];
        end
    end

    // memory write port: clearing pass or event update
    assign w_mem_we  = i_cmd.clr_wr || i_cmd.upd_wr;
    assign w_wr_addr = i_cmd.clr_wr ? r_clr_addr : r_addr;
    assign w_wr_cnt  = i_cmd.clr_wr ? '0 : w_new_cnt;
    assign w_wr_sum  = i_cmd.clr_wr ? '0 : w_new_sum;

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            mem_cnt[w_wr_addr] <= w_wr_cnt;
            mem_sum[w_wr_addr] <= w_wr_sum;
        end
    end

    // registered memory read
    always_ff @(posedge i_clk) begin
        r_rd_cnt <= mem_cnt[w_rd_addr];
        r_rd_sum <= mem_sum[w_rd_addr];
    end

    // restoring divider, one quotient bit per cycle
    assign w_mag     = r_rd_sum[tcmp_pkg::CHG_W-1] ? (-r_rd_sum) : r_rd_sum;
    assign w_rem_sh  = {r_rem, r_dq[DW-1]};
    assign w_ge      = (w_rem_sh >= {1'b0, r_tot});
    assign w_rem_sub = w_rem_sh - {1'b0, r_tot};

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_load) begin
            r_tot  <= r_rd_cnt;
            r_chg  <= r_rd_sum;
            r_neg  <= r_rd_sum[tcmp_pkg::CHG_W-1];
            r_dq   <= {w_mag, {tcmp_pkg::FRAC_W{1'b0}}};
            r_rem  <= '0;
            r_step <= '0;
        end else if (i_cmd.div_step) begin
            r_rem  <= w_ge ? w_rem_sub[tcmp_pkg::TOT_W-1:0] : w_rem_sh[tcmp_pkg::TOT_W-1:0];
            r_dq   <= {r_dq[DW-2:0], w_ge};
            r_step <= r_step + 1'b1;
        end
    end
    assign o_stat.div_last = (r_step == tcmp_pkg::STEP_W'(DW - 1));

    // saturate quotient to the mean range, zero for an empty bin
    always_comb begin
        if (r_tot == '0) begin
            w_mean = '0;
        end else if (r_neg) begin
            w_mean = (r_dq > DW'(65536)) ? {1'b1, {(tcmp_pkg::MEAN_W-1){1'b0}}}
                                         : -$signed(r_dq[tcmp_pkg::MEAN_W-1:0]);
        end else begin
            w_mean = (r_dq > DW'(65535)) ? {1'b0, {(tcmp_pkg::MEAN_W-1){1'b1}}}
                                         : $signed(r_dq[tcmp_pkg::MEAN_W-1:0]);
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_m_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_m_data <= {{(tcmp_pkg::M_TDATA_W-tcmp_pkg::M_USED_W){1'b0}},
                         w_mean, r_chg, r_tot, r_bin_idx};
        end
    end

    assign o_stat.out_busy = r_m_valid && !i_m_tready;
    assign o_m_tvalid      = r_m_valid;
    assign o_m_tdata       = r_m_data;

endmodule

/* src/track_cut_multiplicity_profile.sv */
// ----------------------------------------------------------------------------
// track_cut_multiplicity_profile
// an end of event does a read-modify-write of one histogram bin; a bin read
// runs memory read, divider load, 48 radix-2 divider steps and output load,
// which waits while a result is stalled; tracks at 1 per cycle while idle,
// the input is closed during a bin read or end of event
// reset: synchronous, active low; after reset a clearing pass zeroes
// the histogram memory with s_axis_tready low, config writes are taken
// ----------------------------------------------------------------------------
module track_cut_multiplicity_profile (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // input transactions
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // pt[19:0], eta[35:20], pid[67:36], bin_select[75:68], zero pad
    input  logic [tcmp_pkg::S_TDATA_W-1:0]    s_axis_tdata,
    // cmd[1:0]
    input  logic [tcmp_pkg::CMD_W-1:0]        s_axis_tuser,
    // result transactions
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // bin_index[7:0], event_total[39:8], charge_total[79:40],
    // mean_charge[96:80], zero pad
    output logic [tcmp_pkg::M_TDATA_W-1:0]    m_axis_tdata,
    // configuration writes
    input  logic                              i_cfg_wr_en,
    input  logic [tcmp_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [tcmp_pkg::CFG_DATA_W-1:0]   i_cfg_wdata
);

    tcmp_pkg::t_dp_cmd  w_cmd;
    tcmp_pkg::t_dp_stat w_stat;

    // sequencer
    tcmp_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_axis_tvalid),
        .i_s_cmd   (s_axis_tuser),
        .i_stat    (w_stat),
        .o_s_ready (s_axis_tready),
        .o_cmd     (w_cmd)
    );

    // datapath
    tcmp_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_s_cmd     (s_axis_tuser),
        .i_s_data    (s_axis_tdata),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_m_tready  (m_axis_tready),
        .o_m_tvalid  (m_axis_tvalid),
        .o_m_tdata   (m_axis_tdata)
    );

endmodule

/* src/tcmp_checker.sv */
// ----------------------------------------------------------------------------
// tcmp_checker
// port-level checks on the multiplicity profile, bound to the top level
// ----------------------------------------------------------------------------
module tcmp_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tready,
    input  logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    input  logic [tcmp_pkg::M_TDATA_W-1:0]    m_axis_tdata
);

    logic [tcmp_pkg::TOT_W-1:0]  w_tot;
    logic [tcmp_pkg::CHG_W-1:0]  w_chg;
    logic [tcmp_pkg::MEAN_W-1:0] w_mean;

    assign w_tot  = m_axis_tdata[tcmp_pkg::TOT_LSB  +: tcmp_pkg::TOT_W];
    assign w_chg  = m_axis_tdata[tcmp_pkg::CHG_LSB  +: tcmp_pkg::CHG_W];
    assign w_mean = m_axis_tdata[tcmp_pkg::MEAN_LSB +: tcmp_pkg::MEAN_W];

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    // input side is closed right after reset, when the clearing pass starts
    a_clear_closed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !s_axis_tready)
        else $error("input accepted during clearing pass");

    // an empty bin reports zero charge and zero mean
    a_empty_bin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (w_tot == '0) |-> (w_chg == '0) && (w_mean == '0))
        else $error("empty bin with nonzero charge or mean");

    // mean is never negative for a non-negative charge sum
    a_mean_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !w_chg[tcmp_pkg::CHG_W-1] |-> !w_mean[tcmp_pkg::MEAN_W-1])
        else $error("negative mean for a non-negative charge sum");

endmodule

bind track_cut_multiplicity_profile tcmp_checker u_tcmp_checker (.*);
